[design/assert_macros.svh]
// Assertion helpers shared by the unique value stack modules.
// The macros expect signals named clock and reset in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, switched off while reset is high.
`define USV_CHECK(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked property that also holds across reset.
`define USV_CHECK_RST(name, prop, msg) \
   name: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

[design/usv_pkg.sv]
// ----------------------------------------------------------------------------
// usv_pkg
// Types and constants shared by the unique value stack front end, request
// queue and execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

package usv_pkg;

   localparam int DEPTH    = 16;
   localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W  = 5;
   localparam int KIND_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 4;
   localparam int STATUS_W = 3;

   // Request kinds as they arrive on the request port.
   localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

   // Decoded operation, one-hot.
   typedef enum logic [3:0] {
      OP_PUSH = 4'b0001,
      OP_POP  = 4'b0010,
      OP_READ = 4'b0100,
      OP_NOP  = 4'b1000
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 3'd0,
      ST_DUP   = 3'd1,
      ST_FULL  = 3'd2,
      ST_EMPTY = 3'd3,
      ST_RANGE = 3'd4
   } status_type;

   typedef struct packed {
      op_type                     op;
      logic signed [VALUE_W-1:0]  value;
      logic        [POS_W-1:0]    position;
   } item_type;

endpackage

`default_nettype wire

[design/unique_value_stack_top.sv]
// A push, pop or read request passes a search step and a commit step in the
// execution back end: the search compares the value against all live entries
// and fetches the addressed entry, the commit updates the stack and registers
// the response. The back end takes no new request until the last one has
// committed. A two-entry queue lets requests be taken while the back end is
// busy or a response waits.
// ----------------------------------------------------------------------------
// unique_value_stack_top
// Stack of up to 16 signed 32-bit values that ignores pushes of values already
// stored; every response carries the entry count after the request.
// ----------------------------------------------------------------------------
`default_nettype none

module unique_value_stack_top (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire        [usv_pkg::KIND_W-1:0]    req_kind,
   input  wire signed [usv_pkg::VALUE_W-1:0]   req_value,
   input  wire        [usv_pkg::POS_W-1:0]     req_position,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic signed [usv_pkg::VALUE_W-1:0]  rsp_data,
   output logic        [usv_pkg::STATUS_W-1:0] rsp_status,
   output logic        [usv_pkg::COUNT_W-1:0]  rsp_count
);
   import usv_pkg::*;

   item_type q_wdata;
   item_type q_rdata;
   logic     q_push;
   logic     q_pop;
   logic     q_full;
   logic     q_empty;

   usv_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_kind     (req_kind),
      .req_value    (req_value),
      .req_position (req_position),
      .req_stall    (req_stall),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_wdata      (q_wdata)
   );

   usv_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   usv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_item     (q_rdata),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count)
   );

endmodule

`default_nettype wire

[design/usv_front.sv]
// ----------------------------------------------------------------------------
// usv_front
// Accepts requests, decodes the kind into an operation and hands the
// decoded request to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module usv_front (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   input  wire        [usv_pkg::KIND_W-1:0]    req_kind,
   input  wire signed [usv_pkg::VALUE_W-1:0]   req_value,
   input  wire        [usv_pkg::POS_W-1:0]     req_position,
   output logic                                req_stall,
   input  wire                                 q_full,
   output logic                                q_push,
   output usv_pkg::item_type                   q_wdata
);
   import usv_pkg::*;

   logic     hold_vld_ff, hold_vld_in;
   item_type hold_item_ff;
   item_type dec_item;
   logic     accept;

   always_comb begin
      dec_item.value    = req_value;
      dec_item.position = req_position;
      unique case (req_kind)
         KIND_PUSH: dec_item.op = OP_PUSH;
         KIND_POP:  dec_item.op = OP_POP;
         KIND_READ: dec_item.op = OP_READ;
         default:   dec_item.op = OP_NOP;
      endcase
   end

   assign q_push    = hold_vld_ff && !q_full;
   assign q_wdata   = hold_item_ff;
   assign req_stall = hold_vld_ff && q_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      hold_vld_in = hold_vld_ff;
      if (accept) begin
         hold_vld_in = 1'b1;
      end else if (q_push) begin
         hold_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
      end else begin
         hold_vld_ff <= hold_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_item_ff <= dec_item;
      end
   end

endmodule

`default_nettype wire

[design/usv_queue.sv]
// ----------------------------------------------------------------------------
// usv_queue
// Two-entry queue of decoded requests between the front end and the
// execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module usv_queue (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  wire usv_pkg::item_type  wdata,
   output logic                    full,
   input  wire                     pop,
   output usv_pkg::item_type       rdata,
   output logic                    empty
);
   import usv_pkg::*;

   localparam int QDEPTH = 2;

   item_type         slot_ff [QDEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;

   assign full  = (cnt_ff == 2'(QDEPTH));
   assign empty = (cnt_ff == 2'd0);
   assign rdata = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

   `USV_CHECK(a_queue_no_overflow, !(push && full), "push into a full request queue")
   `USV_CHECK(a_queue_no_underflow, !(pop && empty), "pop from an empty request queue")

endmodule

`default_nettype wire

[design/usv_back.sv]
// ----------------------------------------------------------------------------
// usv_back
// Holds the stack and executes queued requests in two steps: a search step
// that compares the value against all live entries and fetches the addressed
// entry, and a commit step that updates the stack and loads the response.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module usv_back (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire usv_pkg::item_type              q_item,
   input  wire                                 q_empty,
   output logic                                q_pop,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic signed [usv_pkg::VALUE_W-1:0]  rsp_data,
   output logic        [usv_pkg::STATUS_W-1:0] rsp_status,
   output logic        [usv_pkg::COUNT_W-1:0]  rsp_count
);
   import usv_pkg::*;

   typedef enum logic [1:0] {
      S_SEARCH = 2'b01,
      S_COMMIT = 2'b10
   } state_type;

   state_type                 state_ff, state_in;
   logic signed [VALUE_W-1:0] entries_ff [DEPTH];
   logic [COUNT_W-1:0]        fill_ff, fill_in;

   // Request held between search and commit.
   op_type                    op_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [POS_W-1:0]          pos_ff;
   logic                      hit_ff;
   logic signed [VALUE_W-1:0] rdata_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_data_ff, rsp_data_in;
   status_type                rsp_status_ff, status_in;
   logic [COUNT_W-1:0]        rsp_count_ff;

   logic [DEPTH-1:0]          match_vec;
   logic [COUNT_W-1:0]        fill_m1;
   logic [IDX_W-1:0]          rd_addr;
   logic                      commit;
   logic                      do_write;
   logic                      out_free;

   assign fill_m1  = fill_ff - COUNT_W'(1);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop    = (state_ff == S_SEARCH) && !q_empty;
   assign commit   = (state_ff == S_COMMIT) && out_free;

   // Only entries below the fill level take part in the duplicate search.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match_vec[i] = (entries_ff[i] == q_item.value) && (COUNT_W'(i) < fill_ff);
      end
   end

   always_comb begin
      if (q_item.op == OP_POP) begin
         rd_addr = fill_m1[IDX_W-1:0];
      end else begin
         rd_addr = IDX_W'(q_item.position);
      end
   end

   always_comb begin
      status_in   = ST_OK;
      rsp_data_in = '0;
      fill_in     = fill_ff;
      do_write    = 1'b0;
      unique case (op_ff)
         OP_PUSH: begin
            if (fill_ff >= COUNT_W'(DEPTH)) begin
               status_in = ST_FULL;
            end else if (hit_ff) begin
               status_in = ST_DUP;
            end else begin
               do_write = 1'b1;
               fill_in  = fill_ff + COUNT_W'(1);
            end
         end
         OP_POP: begin
            if (fill_ff == '0) begin
               status_in = ST_EMPTY;
            end else begin
               fill_in     = fill_m1;
               rsp_data_in = rdata_ff;
            end
         end
         OP_READ: begin
            if (COUNT_W'(pos_ff) >= fill_ff) begin
               status_in = ST_RANGE;
            end else begin
               rsp_data_in = rdata_ff;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_SEARCH: if (!q_empty) state_in = S_COMMIT;
         S_COMMIT: if (out_free) state_in = S_SEARCH;
         default:  state_in = S_SEARCH;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SEARCH;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            fill_ff <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         op_ff    <= q_item.op;
         value_ff <= q_item.value;
         pos_ff   <= q_item.position;
         hit_ff   <= |match_vec;
         rdata_ff <= entries_ff[rd_addr];
      end
      if (commit) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= status_in;
         rsp_count_ff  <= fill_in;
      end
      if (commit && do_write) begin
         entries_ff[fill_ff[IDX_W-1:0]] <= value_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

   `USV_CHECK_RST(a_reset_clears, reset |=> (fill_ff == '0 && !rsp_valid_ff), "reset left state")
   `USV_CHECK(a_fill_bound, fill_ff <= COUNT_W'(DEPTH), "fill level above stack depth")
   `USV_CHECK(a_push_grows, (commit && do_write) |=> (fill_ff == $past(fill_ff) + COUNT_W'(1)),
              "accepted push did not grow the stack")
   `USV_CHECK(a_commit_loads, commit |=> rsp_valid_ff, "commit did not present a response")

endmodule

`default_nettype wire
